### src/dcfe_pkg.sv
// ---------------------------------------------------------------------------
// Dual contour face emitter package
// Shared widths, codes and the record types passed between the front part,
// the job queue and the back part.
// ---------------------------------------------------------------------------
package dcfe_pkg;

  localparam int IDX_W         = 18;
  localparam int SAMPLE_W      = 16;
  localparam int CELLS_W       = 7;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 3;
  localparam int MAX_CELLS_DEF = 64;
  localparam int CELLS_RST     = 64;
  localparam int QUEUE_DEPTH   = 4;

  // Register indexes, selected by bit 2 of the byte address.
  localparam int  REG_SEL_BIT = 2;
  localparam logic REG_CELLS  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } dcfe_axis_e;

  // One sample that closes at least one crossed edge.
  typedef struct packed {
    logic [IDX_W-1:0] base;  // cell index of the sample position
    logic [2:0]       hit;   // crossed edges, bit per axis
    logic [2:0]       fall;  // first end inside, bit per axis
  } dcfe_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dcfe_q_status_t;

endpackage

### src/dcfe_front.sv
// ---------------------------------------------------------------------------
// Dual contour face emitter, front part
// Classifies each sample against the threshold, tracks the grid position,
// keeps the plane of inside bits and forms one job per sample that crosses
// at least one edge.
// ---------------------------------------------------------------------------
module dcfe_front
  import dcfe_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  localparam int NW = $clog2(MAX_CELLS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  output logic                       full_o,
  input  logic [NW-1:0]              n_i,
  input  logic signed [SAMPLE_W-1:0] thr_i,
  input  logic                       restart_i,
  input  logic                       q_full_i,
  output logic                       job_push_o,
  output dcfe_job_t                  job_o
);

  localparam int PLANE_DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1);
  localparam int AW          = $clog2(PLANE_DEPTH);

  logic              plane_mem [PLANE_DEPTH];
  logic [NW-1:0]     x_q, y_q, z_q, x_d, y_d, z_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [AW-1:0]     here_q, here_d, above;
  logic              accept, cur;
  logic              x_ge1, y_ge1, z_ge1, x_in, y_in, z_in;
  logic              prev_q;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_cur_q, s1_prev_q, rd_y_q, rd_z_q;
  logic [2:0]        s1_range_q;
  logic [IDX_W-1:0]  s1_base_q;
  logic [2:0]        hit;
  logic              s1_move;

  assign cur    = sample_value_i > thr_i;
  assign accept = push_i && !full_o;
  assign above  = here_q - AW'(n_i) - AW'(1);

  assign x_ge1 = x_q != '0;
  assign y_ge1 = y_q != '0;
  assign z_ge1 = z_q != '0;
  assign x_in  = x_ge1 && (x_q < n_i);
  assign y_in  = y_ge1 && (y_q < n_i);
  assign z_in  = z_ge1 && (z_q < n_i);

  // Raster step; the cell index is linear in x, y and z, so it moves by
  // one along a row, stays put at a row change, drops by n at a plane
  // change and returns to zero at the end of the grid.
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    base_d = base_q;
    here_d = here_q;
    if (restart_i) begin
      x_d    = '0;
      y_d    = '0;
      z_d    = '0;
      base_d = '0;
      here_d = '0;
    end else if (accept) begin
      here_d = here_q + AW'(1);
      if (x_q < n_i) begin
        x_d    = x_q + NW'(1);
        base_d = base_q + IDX_W'(1);
      end else begin
        x_d = '0;
        if (y_q < n_i) begin
          y_d = y_q + NW'(1);
        end else begin
          y_d    = '0;
          here_d = '0;
          if (z_q < n_i) begin
            z_d    = z_q + NW'(1);
            base_d = base_q - IDX_W'(n_i);
          end else begin
            z_d    = '0;
            base_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      base_q <= '0;
      here_q <= '0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      base_q <= base_d;
      here_q <= here_d;
    end
  end

  // Plane store: the old bit at this position is the sample one plane down,
  // the bit one row back is the sample one row down.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      plane_mem[here_q] <= cur;
      rd_z_q            <= plane_mem[here_q];
      rd_y_q            <= plane_mem[above];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_q     <= cur;
      s1_prev_q  <= prev_q;
      s1_cur_q   <= cur;
      s1_base_q  <= base_q;
      s1_range_q <= {z_ge1 && x_in && y_in,
                     y_ge1 && x_in && z_in,
                     x_ge1 && y_in && z_in};
    end
  end

  assign hit = s1_range_q & {rd_z_q ^ s1_cur_q, rd_y_q ^ s1_cur_q, s1_prev_q ^ s1_cur_q};

  assign s1_move    = s1_valid_q && (hit == '0 || !q_full_i);
  assign full_o     = s1_valid_q && hit != '0 && q_full_i;
  assign job_push_o = s1_valid_q && hit != '0 && !q_full_i;
  assign job_o      = '{base: s1_base_q, hit: hit, fall: {rd_z_q, rd_y_q, s1_prev_q}};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

endmodule

### src/dcfe_fifo.sv
// ---------------------------------------------------------------------------
// Dual contour face emitter, job queue
// Short first-in first-out queue of jobs between the front and back parts.
// ---------------------------------------------------------------------------
module dcfe_fifo
  import dcfe_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcfe_job_t      job_i,
  input  logic           pop_i,
  output dcfe_job_t      head_o,
  output dcfe_q_status_t status_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  dcfe_job_t   entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign status_o = '{full: count_q == (PW+1)'(QUEUE_DEPTH), empty: count_q == '0};
  assign head_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PW+1)'(1);
      end
    end
  end

endmodule

### src/dcfe_back.sv
// ---------------------------------------------------------------------------
// Dual contour face emitter, back part
// Takes the job at the head of the queue and emits one quad per cycle into
// the output register while it is empty or popped, in the order X, Y, Z.
// ---------------------------------------------------------------------------
module dcfe_back
  import dcfe_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  localparam int NW = $clog2(MAX_CELLS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcfe_job_t         head_i,
  input  dcfe_q_status_t    q_status_i,
  output logic              q_pop_o,
  input  logic [NW-1:0]     n_i,
  input  logic [IDX_W-1:0]  nsq_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [IDX_W-1:0]  corner_a_o,
  output logic [IDX_W-1:0]  corner_b_o,
  output logic [IDX_W-1:0]  corner_c_o,
  output logic [IDX_W-1:0]  corner_d_o,
  output logic [1:0]        edge_axis_o,
  output logic              edge_polarity_o,
  output logic              last_of_item_o
);

  // Offsets of neighbouring cells: one step back in x, y (n) and z (n*n).
  logic [IDX_W-1:0] off_1n_q, off_1q_q, off_nq_q, off_all_q, off_n_q, off_q_q;
  logic [2:0]       done_q, done_d, pending, sel_mask, rest;
  dcfe_axis_e       axis;
  logic             emit, fall;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] ca, cb, cc, cd;

  always_ff @(posedge clk_i) begin
    off_n_q   <= IDX_W'(n_i);
    off_q_q   <= nsq_i;
    off_1n_q  <= IDX_W'(n_i) + IDX_W'(1);
    off_1q_q  <= nsq_i + IDX_W'(1);
    off_nq_q  <= nsq_i + IDX_W'(n_i);
    off_all_q <= nsq_i + IDX_W'(n_i) + IDX_W'(1);
  end

  assign pending = head_i.hit & ~done_q;

  always_comb begin
    if (pending[AXIS_X]) begin
      axis = AXIS_X;
    end else if (pending[AXIS_Y]) begin
      axis = AXIS_Y;
    end else begin
      axis = AXIS_Z;
    end
  end

  assign sel_mask = 3'b001 << axis;
  assign rest     = pending & ~sel_mask;
  assign fall     = head_i.fall[axis];
  assign emit     = !q_status_i.empty && pending != '0 && (!out_valid_q || pop_i);
  assign q_pop_o  = emit && rest == '0;

  always_comb begin
    ca = head_i.base - off_all_q;
    case (axis)
      AXIS_X: begin
        cb = head_i.base - off_1q_q;
        cc = head_i.base - IDX_W'(1);
        cd = head_i.base - off_1n_q;
      end
      AXIS_Y: begin
        cb = head_i.base - off_1n_q;
        cc = head_i.base - off_n_q;
        cd = head_i.base - off_nq_q;
      end
      default: begin
        cb = head_i.base - off_nq_q;
        cc = head_i.base - off_q_q;
        cd = head_i.base - off_1q_q;
      end
    endcase
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      done_d      = (rest == '0) ? '0 : (done_q | sel_mask);
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Falling edges swap the second and fourth corners.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      corner_a_o      <= ca;
      corner_b_o      <= fall ? cd : cb;
      corner_c_o      <= cc;
      corner_d_o      <= fall ? cb : cd;
      edge_axis_o     <= axis;
      edge_polarity_o <= fall;
      last_of_item_o  <= rest == '0;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

### src/dual_contour_face_emitter.sv
// ---------------------------------------------------------------------------
// Dual contour face emitter
// Turns a raster stream of scalar-field samples into quads of four cell
// indices, one quad for each inner grid edge whose ends lie on opposite
// sides of the iso threshold.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   -------   ---------  ---------------------  -------------------------------
//   sample    in         push_i / full_o        sample_value_i
//   quad      out        empty_o / pop_i        corner_a_o..corner_d_o,
//                                               edge_axis_o, edge_polarity_o,
//                                               last_of_item_o
//   config    in/out     psel/penable/pready    paddr, pwdata, prdata
//
// A sample is taken every cycle while full_o is low; each sample yields up
// to three quads and the back part emits one quad per cycle while the output
// register is free. The first quad of a sample passes the front's s1 register
// and the job queue before the output register offers it. Reset clears the
// position counters, the queue and the output valid flag; the plane store is
// not cleared, as every bit is written before it is read.
// A stalled output fills the job queue and then raises full_o.
//
module dual_contour_face_emitter
  import dcfe_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample transactions
  input  logic                       push_i,
  output logic                       full_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  // quad transactions
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [IDX_W-1:0]           corner_a_o,
  output logic [IDX_W-1:0]           corner_b_o,
  output logic [IDX_W-1:0]           corner_c_o,
  output logic [IDX_W-1:0]           corner_d_o,
  output logic [1:0]                 edge_axis_o,
  output logic                       edge_polarity_o,
  output logic                       last_of_item_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int NW    = $clog2(MAX_CELLS + 1);
  localparam int CW    = (NW > CELLS_W) ? NW : CELLS_W;
  // Cell count in use after reset, clamped to what the plane store holds.
  localparam int N_RST = (CELLS_RST > MAX_CELLS) ? MAX_CELLS : CELLS_RST;

  logic [CELLS_W-1:0]        cells_q;
  logic [NW-1:0]             n_q, n_new;
  logic [IDX_W-1:0]          nsq_q;
  logic [2*NW-1:0]           nsq_new;
  logic signed [SAMPLE_W-1:0] thr_q;
  logic [CW-1:0]             cells_ext;
  logic                      cfg_wr, wr_cells, wr_thresh;

  logic           job_push, q_pop;
  dcfe_job_t      job, head;
  dcfe_q_status_t q_status;

  // -------------------------------------------------------------------------
  // Configuration registers. Writing the cell count restarts the grid pass;
  // counts of zero and above the plane capacity are clamped here, together
  // with the square used for one plane step in the cell index.
  // -------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign wr_cells  = cfg_wr && paddr[REG_SEL_BIT] == REG_CELLS;
  assign wr_thresh = cfg_wr && paddr[REG_SEL_BIT] == REG_THRESH;

  assign cells_ext = CW'(pwdata[CELLS_W-1:0]);

  always_comb begin
    if (cells_ext == '0) begin
      n_new = NW'(1);
    end else if (cells_ext > CW'(MAX_CELLS)) begin
      n_new = NW'(MAX_CELLS);
    end else begin
      n_new = NW'(cells_ext);
    end
  end

  assign nsq_new = n_new * n_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= CELLS_W'(CELLS_RST);
      n_q     <= NW'(N_RST);
      nsq_q   <= IDX_W'(N_RST * N_RST);
      thr_q   <= '0;
    end else begin
      if (wr_cells) begin
        cells_q <= pwdata[CELLS_W-1:0];
        n_q     <= n_new;
        nsq_q   <= IDX_W'(nsq_new);
      end
      if (wr_thresh) begin
        thr_q <= pwdata[SAMPLE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[REG_SEL_BIT] == REG_THRESH) begin
      prdata = {{(DATA_W-SAMPLE_W){thr_q[SAMPLE_W-1]}}, thr_q};
    end else begin
      prdata = DATA_W'(cells_q);
    end
  end

  // -------------------------------------------------------------------------
  // Front part: classification, position tracking and the plane store.
  // -------------------------------------------------------------------------
  dcfe_front #(
    .MAX_CELLS(MAX_CELLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .sample_value_i(sample_value_i),
    .full_o        (full_o),
    .n_i           (n_q),
    .thr_i         (thr_q),
    .restart_i     (wr_cells),
    .q_full_i      (q_status.full),
    .job_push_o    (job_push),
    .job_o         (job)
  );

  // -------------------------------------------------------------------------
  // Job queue: lets the front keep taking samples while quads drain.
  // -------------------------------------------------------------------------
  dcfe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (q_pop),
    .head_o  (head),
    .status_o(q_status)
  );

  // -------------------------------------------------------------------------
  // Back part: one quad per cycle into the output register while it is free.
  // -------------------------------------------------------------------------
  dcfe_back #(
    .MAX_CELLS(MAX_CELLS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_status_i     (q_status),
    .q_pop_o        (q_pop),
    .n_i            (n_q),
    .nsq_i          (nsq_q),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .corner_d_o     (corner_d_o),
    .edge_axis_o    (edge_axis_o),
    .edge_polarity_o(edge_polarity_o),
    .last_of_item_o (last_of_item_o)
  );

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // The front never writes a job into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !q_status.full)
    else $error("job written into a full queue");

  // The back part only retires a job that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("job retired from an empty queue");

  // Back-pressure on the sample side only comes from a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> q_status.full)
    else $error("sample side stalled with room in the queue");

  // A retired job leaves the output holding its final quad.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (!empty_o && last_of_item_o))
    else $error("job retired without its final quad");

endmodule
